>>> sv/bmsm_pkg.sv
package bmsm_pkg;

	localparam int NUM_STACKS_DEF = 64;
	localparam int MAX_DEPTH_DEF  = 16;

	localparam int CAP_W = 5;
	localparam int VAL_W = 16;
	localparam int IDX_W = 6;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [1:0] KIND_PUSH   = 2'd0;
	localparam logic [1:0] KIND_POP    = 2'd1;
	localparam logic [1:0] KIND_POP_AT = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [VAL_W-1:0] push_value;
		logic [IDX_W-1:0] stack_index;
	} bmsm_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] popped_value;
		logic [1:0]       status;
	} bmsm_out_t;

	typedef struct packed {
		logic init;
		logic sample;
	} bmsm_scan_ctl_t;

endpackage

>>> sv/bmsm_scan.sv
module bmsm_scan
	import bmsm_pkg::*;
#(
	parameter int NUM_STACKS = NUM_STACKS_DEF,
	parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
	localparam int SW = $clog2(NUM_STACKS),
	localparam int CW = $clog2(MAX_DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bmsm_scan_ctl_t ctl,
	input  logic [SW-1:0]  sample_idx,
	input  logic [CW-1:0]  sample_count,
	input  logic [CW-1:0]  eff_cap,
	output logic [SW-1:0]  lnf,
	output logic           rne_vld,
	output logic [SW-1:0]  rne_idx
);

	logic [SW-1:0] lnf_q;
	logic          found_q;
	logic          rne_vld_q;
	logic [SW-1:0] rne_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lnf_q     <= '0;
			found_q   <= 1'b0;
			rne_vld_q <= 1'b0;
			rne_q     <= '0;
		end else if (ctl.init) begin
			lnf_q     <= SW'(NUM_STACKS - 1);
			found_q   <= 1'b0;
			rne_vld_q <= 1'b0;
		end else if (ctl.sample) begin
			if (!found_q && (sample_count < eff_cap)) begin
				lnf_q   <= sample_idx;
				found_q <= 1'b1;
			end
			if (sample_count != '0) begin
				rne_q     <= sample_idx;
				rne_vld_q <= 1'b1;
			end
		end
	end

	assign lnf     = lnf_q;
	assign rne_vld = rne_vld_q;
	assign rne_idx = rne_q;

endmodule

>>> sv/bounded_multi_stack_manager.sv
// A command is taken when start is high and busy is low; its one result appears on result
// for exactly one cycle with done high and cannot be held off, so the receiver must take it.
// After reset the block clears its per-stack counts, one stack per cycle, and then rescans
// them, keeping busy high throughout. A no-op, a pop with every stack empty or a pop at a
// stack beyond the row answers straight from idle; a rejected push or a pop at an empty
// stack answers after reading the count. A push or pop that lands goes on to rescan the
// counts, and a pop first reads the plate memory; both memories have registered read ports,
// and the pointers to the leftmost not-full and rightmost non-empty stacks are rebuilt by a
// scan that reads one count per cycle through the single read port of the count memory.
// Writing the capacity register also starts that scan and holds busy while it runs.
module bounded_multi_stack_manager
	import bmsm_pkg::*;
#(
	parameter int NUM_STACKS = NUM_STACKS_DEF,
	parameter int MAX_DEPTH  = MAX_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bmsm_in_t         cmd,
	output logic             done,
	output bmsm_out_t        result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam int SW = $clog2(NUM_STACKS);
	localparam int CW = $clog2(MAX_DEPTH + 1);
	localparam int AW = $clog2(NUM_STACKS * MAX_DEPTH);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CNT_RD,
		S_CNT_CHK,
		S_POP_RD,
		S_SWEEP,
		S_TAIL
	} state_t;

	state_t           state_q;
	logic [SW-1:0]    sc_q;
	logic [SW-1:0]    tgt_q;
	logic [1:0]       kind_q;
	logic [VAL_W-1:0] val_q;
	logic [AW-1:0]    base_q;
	logic             done_q;
	bmsm_out_t        res_q;
	logic             sample_v_q;
	logic [SW-1:0]    sample_idx_q;
	logic [CAP_W-1:0] cap_q;

	logic [CW-1:0]    counts [NUM_STACKS];
	logic [CW-1:0]    cnt_rd_q;
	logic [VAL_W-1:0] store [NUM_STACKS * MAX_DEPTH];
	logic [VAL_W-1:0] st_rd_q;

	logic [SW-1:0]    cnt_raddr;
	logic [SW-1:0]    cnt_waddr;
	logic             cnt_we;
	logic [CW-1:0]    cnt_wdata;
	logic             st_we;
	logic             st_re;
	logic [AW-1:0]    st_addr;
	logic [CW-1:0]    eff_cap;
	logic             cfg_wr;
	logic             is_push;
	logic             can_push;
	logic             can_pop;
	logic             done_d;

	bmsm_scan_ctl_t   scan_ctl;
	logic [SW-1:0]    lnf;
	logic             rne_vld;
	logic [SW-1:0]    rne_idx;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (int'(cap_q) > MAX_DEPTH) begin
			eff_cap = CW'(MAX_DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_CLEAR) || ((state_q == S_IDLE) && !start);
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign is_push   = (kind_q == KIND_PUSH);
	assign can_push  = (cnt_rd_q < eff_cap);
	assign can_pop   = (cnt_rd_q != '0);

	always_comb begin
		cnt_raddr = (state_q == S_SWEEP) ? sc_q : tgt_q;
		cnt_waddr = (state_q == S_CLEAR) ? sc_q : tgt_q;
		cnt_we    = 1'b0;
		cnt_wdata = '0;
		st_we     = 1'b0;
		st_re     = 1'b0;
		st_addr   = base_q + AW'(cnt_rd_q);
		if (state_q == S_CLEAR) begin
			cnt_we = 1'b1;
		end else if (state_q == S_CNT_CHK) begin
			if (is_push) begin
				if (can_push) begin
					cnt_we    = 1'b1;
					cnt_wdata = cnt_rd_q + CW'(1);
					st_we     = 1'b1;
				end
			end else if (can_pop) begin
				cnt_we    = 1'b1;
				cnt_wdata = cnt_rd_q - CW'(1);
				st_re     = 1'b1;
				st_addr   = base_q + AW'(cnt_rd_q - CW'(1));
			end
		end
	end

	always_comb begin
		done_d = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd.kind)
						KIND_PUSH:   done_d = 1'b0;
						KIND_POP:    done_d = !rne_vld;
						KIND_POP_AT: done_d = (32'(cmd.stack_index) >= 32'(NUM_STACKS));
						default:     done_d = 1'b1;
					endcase
				end
			end
			S_CNT_CHK: done_d = is_push || !can_pop;
			S_POP_RD:  done_d = 1'b1;
			default:   done_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			counts[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= counts[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store[st_addr] <= val_q;
		end
		if (st_re) begin
			st_rd_q <= store[st_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			sc_q         <= '0;
			tgt_q        <= '0;
			kind_q       <= KIND_PUSH;
			val_q        <= '0;
			base_q       <= '0;
			done_q       <= 1'b0;
			res_q        <= '0;
			sample_v_q   <= 1'b0;
			sample_idx_q <= '0;
			cap_q        <= CAP_RESET;
		end else begin
			done_q     <= done_d;
			sample_v_q <= (state_q == S_SWEEP);
			if (cfg_wr) begin
				cap_q <= cfg_data;
			end
			case (state_q)
				S_CLEAR: begin
					if (sc_q == SW'(NUM_STACKS - 1)) begin
						sc_q    <= '0;
						state_q <= S_SWEEP;
					end else begin
						sc_q <= sc_q + SW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						kind_q <= cmd.kind;
						val_q  <= cmd.push_value;
						case (cmd.kind)
							KIND_PUSH: begin
								res_q   <= '0;
								tgt_q   <= lnf;
								state_q <= S_CNT_RD;
							end
							KIND_POP: begin
								if (rne_vld) begin
									res_q   <= '0;
									tgt_q   <= rne_idx;
									state_q <= S_CNT_RD;
								end else begin
									res_q <= '{popped_value: '0, status: STATUS_EMPTY};
								end
							end
							KIND_POP_AT: begin
								if (32'(cmd.stack_index) < 32'(NUM_STACKS)) begin
									res_q   <= '0;
									tgt_q   <= SW'(cmd.stack_index);
									state_q <= S_CNT_RD;
								end else begin
									res_q <= '{popped_value: '0, status: STATUS_EMPTY};
								end
							end
							default: begin
								res_q <= '0;
							end
						endcase
					end else if (cfg_wr) begin
						sc_q    <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_CNT_RD: begin
					base_q  <= AW'(tgt_q * MAX_DEPTH);
					state_q <= S_CNT_CHK;
				end
				S_CNT_CHK: begin
					if (is_push) begin
						if (can_push) begin
							res_q.status <= STATUS_OK;
							sc_q         <= '0;
							state_q      <= S_SWEEP;
						end else begin
							res_q.status <= STATUS_FULL;
							state_q      <= S_IDLE;
						end
					end else if (can_pop) begin
						state_q <= S_POP_RD;
					end else begin
						res_q.status <= STATUS_EMPTY;
						state_q      <= S_IDLE;
					end
				end
				S_POP_RD: begin
					res_q   <= '{popped_value: st_rd_q, status: STATUS_OK};
					sc_q    <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					sample_idx_q <= sc_q;
					if (sc_q == SW'(NUM_STACKS - 1)) begin
						state_q <= S_TAIL;
					end else begin
						sc_q <= sc_q + SW'(1);
					end
				end
				S_TAIL: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign scan_ctl.init   = (state_q == S_SWEEP) && (sc_q == '0);
	assign scan_ctl.sample = sample_v_q;

	bmsm_scan #(
		.NUM_STACKS(NUM_STACKS),
		.MAX_DEPTH (MAX_DEPTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.sample_idx  (sample_idx_q),
		.sample_count(cnt_rd_q),
		.eff_cap     (eff_cap),
		.lnf         (lnf),
		.rne_vld     (rne_vld),
		.rne_idx     (rne_idx)
	);

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> sv/bmsm_chk.sv
module bmsm_chk
	import bmsm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input bmsm_out_t result,
	input logic      cfg_valid,
	input logic      cfg_ready
);

	// Every accepted command either answers at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted command neither answered nor held busy");

	// A result only follows an accepted command or a cycle of work.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result strobe without a command");

	// A failed command returns no value.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != STATUS_OK)) |-> (result.popped_value == '0))
		else $error("failed command returned a value");

	// A capacity write never coincides with an accepted command.
	a_cfg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> !(start && !busy))
		else $error("capacity write together with a command");

endmodule

bind bounded_multi_stack_manager bmsm_chk u_chk (.*);
